/* rtl/vna_pkg.sv */
// Shared types, widths and command codes of the vertex normal accumulator.
package vna_pkg;

  // Store and number formats.
  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int COORD_BITS   = 16;
  localparam int SUM_BITS     = 48;
  localparam int EDGE_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int NORM_W       = 16;

  // Normalization unit widths: the largest magnitude is scaled into [2^23, 2^24).
  localparam int MAG_W   = 24;
  localparam int FRAC_W  = 14;
  localparam int SQ_W    = 2 * MAG_W + 2;
  localparam int ROOT_W  = SQ_W + 1;
  localparam int LEN_W   = MAG_W + 1;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int NUM_W   = MAG_W + FRAC_W + 1;

  // Command codes carried in the kind field.
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TRI   = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [VIDX_W-1:0]             index_a;
    logic [VIDX_W-1:0]             index_b;
    logic [VIDX_W-1:0]             index_c;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } pos_row_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] x;
    logic signed [SUM_BITS-1:0] y;
    logic signed [SUM_BITS-1:0] z;
  } sum_vec_t;

  typedef struct packed {
    logic     ovf;
    sum_vec_t s;
  } sum_row_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
    logic                     zero;
  } norm_res_t;

  // Queue handshake between the front and the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

endpackage

/* rtl/vna_front.sv */
// Front end: takes commands, decodes them and queues them for the back end.
module vna_front import vna_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_kind,
  input  logic [VIDX_W-1:0]      in_index_a,
  input  logic [VIDX_W-1:0]      in_index_b,
  input  logic [VIDX_W-1:0]      in_index_c,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic                   init_done,
  input  logic                   q_pop,
  output q_out_t                 q_out
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       push;

  // Build the queued command; only a write keeps its coordinates.
  always_comb begin
    cmd_in         = '0;
    cmd_in.kind    = in_kind;
    cmd_in.index_a = in_index_a;
    case (in_kind)
      KIND_WRITE: begin
        cmd_in.pos_x = in_pos_x;
        cmd_in.pos_y = in_pos_y;
        cmd_in.pos_z = in_pos_z;
      end
      KIND_TRI: begin
        cmd_in.index_b = in_index_b;
        cmd_in.index_c = in_index_c;
      end
      default: begin
      end
    endcase
  end

  // Hold off transfers while the queue is full or the sums are being cleared after reset.
  assign busy  = (cnt_r == 2'd2) || !init_done;
  assign push  = start && !busy;
  assign q_out = '{valid: (cnt_r != 2'd0), cmd: fifo_r[rd_ptr_r]};

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

/* rtl/vna_norm.sv */
// Normalization unit: scales a sum vector to unit length in Q1.14, a step per cycle.
module vna_norm import vna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  sum_vec_t  sums,
  output logic      done,
  output norm_res_t res
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLOAD = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]              st_r;
  logic [SUM_BITS-1:0]     mag_r [3];
  logic [2:0]              neg_r;
  logic [3:0]              cnt_r;
  logic [2*MAG_W-1:0]      prod_r;
  logic [SQ_W-1:0]         acc_r;
  logic [ROOT_W-1:0]       x_r;
  logic [ROOT_W-1:0]       root_r;
  logic [ROOT_W-1:0]       bit_r;
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        rem_r;
  logic [FRAC_W:0]         nb_r;
  logic [QUO_W-1:0]        q_r;
  logic [1:0]              comp_r;
  logic                    done_r;
  norm_res_t               res_r;

  logic [SUM_BITS-1:0]     m;
  logic [SUM_BITS-1:0]     mag_in [3];
  logic [MAG_W-1:0]        sq_op;
  logic [SQ_W-1:0]         acc_sum;
  logic [ROOT_W-1:0]       trial;
  logic [MAG_W-1:0]        div_a;
  logic [NUM_W-1:0]        numer;
  logic [LEN_W:0]          dtrial;
  logic                    qbit;
  logic [QUO_W-1:0]        q_full;
  logic signed [NORM_W-1:0] q_signed;

  // Magnitudes of the incoming sums.
  always_comb begin
    mag_in[0] = sums.x[SUM_BITS-1] ? SUM_BITS'(-sums.x) : SUM_BITS'(sums.x);
    mag_in[1] = sums.y[SUM_BITS-1] ? SUM_BITS'(-sums.y) : SUM_BITS'(sums.y);
    mag_in[2] = sums.z[SUM_BITS-1] ? SUM_BITS'(-sums.z) : SUM_BITS'(sums.z);
  end

  // Largest magnitude drives the common scaling shift.
  always_comb begin
    m = mag_r[0];
    if (mag_r[1] > m) begin
      m = mag_r[1];
    end
    if (mag_r[2] > m) begin
      m = mag_r[2];
    end
  end

  // Operand selection for squaring, root trial and division.
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op = mag_r[0][MAG_W-1:0];
      2'd1:    sq_op = mag_r[1][MAG_W-1:0];
      default: sq_op = mag_r[2][MAG_W-1:0];
    endcase
    case (comp_r)
      2'd0:    div_a = mag_r[0][MAG_W-1:0];
      2'd1:    div_a = mag_r[1][MAG_W-1:0];
      default: div_a = mag_r[2][MAG_W-1:0];
    endcase
    acc_sum  = acc_r + SQ_W'(prod_r);
    trial    = root_r + bit_r;
    numer    = {1'b0, div_a, {FRAC_W{1'b0}}} + NUM_W'(len_r >> 1);
    dtrial   = {rem_r, nb_r[FRAC_W]};
    qbit     = (dtrial >= {1'b0, len_r});
    q_full   = {q_r[QUO_W-2:0], qbit};
    q_signed = neg_r[comp_r] ? -NORM_W'(q_full) : NORM_W'(q_full);
  end

  // Sequencer: a zero sum is flagged directly; else scale, sum of squares, bit-serial root, three long divisions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        N_IDLE: begin
          if (go) begin
            mag_r[0] <= mag_in[0];
            mag_r[1] <= mag_in[1];
            mag_r[2] <= mag_in[2];
            neg_r    <= {sums.z[SUM_BITS-1], sums.y[SUM_BITS-1], sums.x[SUM_BITS-1]};
            res_r    <= '0;
            if ((mag_in[0] | mag_in[1] | mag_in[2]) == '0) begin
              res_r.zero <= 1'b1;
              done_r     <= 1'b1;
            end else begin
              st_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (m[SUM_BITS-1:MAG_W] != '0) begin
            mag_r[0] <= mag_r[0] >> 1;
            mag_r[1] <= mag_r[1] >> 1;
            mag_r[2] <= mag_r[2] >> 1;
          end else if (!m[MAG_W-1]) begin
            mag_r[0] <= mag_r[0] << 1;
            mag_r[1] <= mag_r[1] << 1;
            mag_r[2] <= mag_r[2] << 1;
          end else begin
            st_r  <= N_SQ;
            cnt_r <= '0;
            acc_r <= '0;
          end
        end
        N_SQ: begin
          prod_r <= sq_op * sq_op;
          cnt_r  <= cnt_r + 4'd1;
          if (cnt_r != '0) begin
            acc_r <= acc_sum;
          end
          if (cnt_r == 4'd3) begin
            x_r    <= ROOT_W'(acc_sum);
            root_r <= '0;
            bit_r  <= ROOT_W'(1) << (SQ_W);
            st_r   <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (x_r >= trial) begin
            x_r    <= x_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            len_r  <= (x_r >= trial) ? LEN_W'((root_r >> 1) + bit_r) : LEN_W'(root_r >> 1);
            comp_r <= 2'd0;
            st_r   <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem_r <= LEN_W'(numer[NUM_W-1:QUO_W]);
          nb_r  <= numer[QUO_W-1:0];
          q_r   <= '0;
          cnt_r <= '0;
          st_r  <= N_DIV;
        end
        N_DIV: begin
          rem_r <= qbit ? LEN_W'(dtrial - {1'b0, len_r}) : LEN_W'(dtrial);
          nb_r  <= nb_r << 1;
          q_r   <= q_full;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(QUO_W - 1)) begin
            case (comp_r)
              2'd0:    res_r.x <= q_signed;
              2'd1:    res_r.y <= q_signed;
              default: res_r.z <= q_signed;
            endcase
            if (comp_r == 2'd2) begin
              done_r <= 1'b1;
              st_r   <= N_IDLE;
            end else begin
              comp_r <= comp_r + 2'd1;
              st_r   <= N_DLOAD;
            end
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/vna_back.sv */
// Back end: position and sum stores, triangle cross product and read sequencing.
module vna_back import vna_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  q_out_t                   q_out,
  output logic                     q_pop,
  output logic                     init_done,
  output logic                     out_strobe,
  output logic signed [NORM_W-1:0] out_normal_x,
  output logic signed [NORM_W-1:0] out_normal_y,
  output logic signed [NORM_W-1:0] out_normal_z,
  output logic                     out_zero_sum,
  output logic                     out_saturated
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RA    = 4'd2;
  localparam logic [3:0] S_RB    = 4'd3;
  localparam logic [3:0] S_RC    = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_SR    = 4'd7;
  localparam logic [3:0] S_SW    = 4'd8;
  localparam logic [3:0] S_RS    = 4'd9;
  localparam logic [3:0] S_RL    = 4'd10;
  localparam logic [3:0] S_NWAIT = 4'd11;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Storage.
  pos_row_t pos_mem [MAX_VERTICES];
  sum_row_t sum_mem [MAX_VERTICES];

  logic [3:0]               state_r;
  logic [VIDX_W-1:0]        addr_cnt_r;
  logic                     init_done_r;
  cmd_t                     cmd_r;
  pos_row_t                 pos_rd_r;
  sum_row_t                 sum_rd_r;
  pos_row_t                 pa_r;
  pos_row_t                 pb_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CROSS_W-1:0] n_r [3];
  logic [2:0]               mul_cnt_r;
  logic [1:0]               corner_r;
  logic                     ovf_r;
  logic                     strobe_r;
  norm_res_t                out_r;

  logic                     pos_we;
  logic [VIDX_W-1:0]        pos_ra;
  pos_row_t                 pos_wd;
  logic                     sum_we;
  logic [VIDX_W-1:0]        sum_wa;
  logic [VIDX_W-1:0]        sum_ra;
  sum_row_t                 sum_wd;
  logic [VIDX_W-1:0]        corner_idx;
  logic signed [EDGE_W-1:0] mul_a;
  logic signed [EDGE_W-1:0] mul_b;
  logic [SUM_BITS:0]        add_x;
  logic [SUM_BITS:0]        add_y;
  logic [SUM_BITS:0]        add_z;
  sum_row_t                 new_row;
  logic                     norm_go;
  logic                     norm_done;
  norm_res_t                norm_res;

  // Saturating add of a cross product component; top bit flags clamping.
  function automatic logic [SUM_BITS:0] sat_add(input logic signed [SUM_BITS-1:0] a,
                                                 input logic signed [CROSS_W-1:0] b);
    logic signed [SUM_BITS:0] s;
    s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return {1'b1, s[SUM_BITS] ? SUM_MIN : SUM_MAX};
    end
    return {1'b0, s[SUM_BITS-1:0]};
  endfunction

  // Memory port control.
  always_comb begin
    case (corner_r)
      2'd0:    corner_idx = cmd_r.index_a;
      2'd1:    corner_idx = cmd_r.index_b;
      default: corner_idx = cmd_r.index_c;
    endcase
    q_pop  = (state_r == S_IDLE) && q_out.valid;
    pos_we = q_pop && (q_out.cmd.kind == KIND_WRITE);
    pos_wd = '{x: q_out.cmd.pos_x, y: q_out.cmd.pos_y, z: q_out.cmd.pos_z};
    case (state_r)
      S_RB:    pos_ra = cmd_r.index_b;
      S_RC:    pos_ra = cmd_r.index_c;
      default: pos_ra = cmd_r.index_a;
    endcase
    sum_ra = (state_r == S_SR) ? corner_idx : cmd_r.index_a;

    add_x = sat_add(sum_rd_r.s.x, n_r[0]);
    add_y = sat_add(sum_rd_r.s.y, n_r[1]);
    add_z = sat_add(sum_rd_r.s.z, n_r[2]);
    new_row.s.x = add_x[SUM_BITS-1:0];
    new_row.s.y = add_y[SUM_BITS-1:0];
    new_row.s.z = add_z[SUM_BITS-1:0];
    new_row.ovf = sum_rd_r.ovf | add_x[SUM_BITS] | add_y[SUM_BITS] | add_z[SUM_BITS];

    sum_we = 1'b0;
    sum_wa = addr_cnt_r;
    sum_wd = '0;
    case (state_r)
      S_CLR: sum_we = 1'b1;
      S_SW: begin
        sum_we = 1'b1;
        sum_wa = corner_idx;
        sum_wd = new_row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[q_out.cmd.index_a] <= pos_wd;
    end
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd_r <= sum_mem[sum_ra];
  end

  // Cross product operands, one product per cycle.
  always_comb begin
    case (mul_cnt_r)
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      default: begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
    endcase
  end

  assign norm_go = (state_r == S_RL);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_cnt_r  <= '0;
      init_done_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          addr_cnt_r <= addr_cnt_r + 1'b1;
          if (addr_cnt_r == VIDX_W'(MAX_VERTICES - 1)) begin
            init_done_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_out.valid) begin
            cmd_r <= q_out.cmd;
            case (q_out.cmd.kind)
              KIND_CLEAR: begin
                addr_cnt_r <= '0;
                state_r    <= S_CLR;
              end
              KIND_TRI:  state_r <= S_RA;
              KIND_READ: state_r <= S_RS;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          pa_r    <= pos_rd_r;
          state_r <= S_RC;
        end
        S_RC: begin
          pb_r    <= pos_rd_r;
          state_r <= S_RD;
        end
        S_RD: begin
          e1_r[0] <= {pb_r.x[COORD_BITS-1], pb_r.x} - {pa_r.x[COORD_BITS-1], pa_r.x};
          e1_r[1] <= {pb_r.y[COORD_BITS-1], pb_r.y} - {pa_r.y[COORD_BITS-1], pa_r.y};
          e1_r[2] <= {pb_r.z[COORD_BITS-1], pb_r.z} - {pa_r.z[COORD_BITS-1], pa_r.z};
          e2_r[0] <= {pos_rd_r.x[COORD_BITS-1], pos_rd_r.x} - {pb_r.x[COORD_BITS-1], pb_r.x};
          e2_r[1] <= {pos_rd_r.y[COORD_BITS-1], pos_rd_r.y} - {pb_r.y[COORD_BITS-1], pb_r.y};
          e2_r[2] <= {pos_rd_r.z[COORD_BITS-1], pos_rd_r.z} - {pb_r.z[COORD_BITS-1], pb_r.z};
          mul_cnt_r <= '0;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          prod_r    <= mul_a * mul_b;
          mul_cnt_r <= mul_cnt_r + 3'd1;
          case (mul_cnt_r)
            3'd1: n_r[0] <= CROSS_W'(prod_r);
            3'd2: n_r[0] <= n_r[0] - CROSS_W'(prod_r);
            3'd3: n_r[1] <= CROSS_W'(prod_r);
            3'd4: n_r[1] <= n_r[1] - CROSS_W'(prod_r);
            3'd5: n_r[2] <= CROSS_W'(prod_r);
            3'd6: n_r[2] <= n_r[2] - CROSS_W'(prod_r);
            default: begin
            end
          endcase
          if (mul_cnt_r == 3'd6) begin
            corner_r <= 2'd0;
            state_r  <= S_SR;
          end
        end
        S_SR: state_r <= S_SW;
        S_SW: begin
          if (corner_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            corner_r <= corner_r + 2'd1;
            state_r  <= S_SR;
          end
        end
        S_RS: state_r <= S_RL;
        S_RL: begin
          ovf_r   <= sum_rd_r.ovf;
          state_r <= S_NWAIT;
        end
        S_NWAIT: begin
          if (norm_done) begin
            out_r    <= norm_res;
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (norm_go),
    .sums  (sum_rd_r.s),
    .done  (norm_done),
    .res   (norm_res)
  );

  assign init_done     = init_done_r;
  assign out_strobe    = strobe_r;
  assign out_normal_x  = out_r.x;
  assign out_normal_y  = out_r.y;
  assign out_normal_z  = out_r.z;
  assign out_zero_sum  = out_r.zero;
  assign out_saturated = ovf_r;

endmodule

/* rtl/vertex_normal_accumulator_core.sv */
// Top level of the area-weighted vertex normal accumulator.
//
//   Channel   Ports                               Transfer
//   command   start, busy, in_*                   start high and busy low at the edge
//   result    out_strobe, out_*                   out_strobe high for one cycle
//
// A write is stored as the back end takes it from the queue; a triangle needs three
// position reads, six products on one multiplier and three sum read-modify-writes
// on the single sum port; a read needs the normalizer's scaling shifts, four
// squaring steps, a 26-step root and three long divisions, or only a flag for a
// zero sum; a clear rewrites every sum row.
// After reset the sum store is cleared in one pass with busy high.
// A two-entry queue lets commands be taken while the back end works.
// Results cannot be held off; each appears for exactly one cycle.
module vertex_normal_accumulator_core import vna_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [VIDX_W-1:0]            in_index_a,
  input  logic [VIDX_W-1:0]            in_index_b,
  input  logic [VIDX_W-1:0]            in_index_c,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  output logic                         out_strobe,
  output logic signed [NORM_W-1:0]     out_normal_x,
  output logic signed [NORM_W-1:0]     out_normal_y,
  output logic signed [NORM_W-1:0]     out_normal_z,
  output logic                         out_zero_sum,
  output logic                         out_saturated
);

  q_out_t q_out;
  logic   q_pop;
  logic   init_done;

  vna_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_index_a (in_index_a),
    .in_index_b (in_index_b),
    .in_index_c (in_index_c),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .init_done  (init_done),
    .q_pop      (q_pop),
    .q_out      (q_out)
  );

  vna_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_out         (q_out),
    .q_pop         (q_pop),
    .init_done     (init_done),
    .out_strobe    (out_strobe),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_normal_z  (out_normal_z),
    .out_zero_sum  (out_zero_sum),
    .out_saturated (out_saturated)
  );

endmodule

/* rtl/vna_checker.sv */
// Port-level checks for the vertex normal accumulator, bound to the top level.
module vna_port_checks import vna_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     busy,
  input logic                     out_strobe,
  input logic signed [NORM_W-1:0] out_normal_x,
  input logic signed [NORM_W-1:0] out_normal_y,
  input logic signed [NORM_W-1:0] out_normal_z,
  input logic                     out_zero_sum
);

  localparam logic signed [NORM_W-1:0] ONE_Q  = NORM_W'(1 << FRAC_W);
  localparam logic signed [NORM_W-1:0] MONE_Q = -NORM_W'(1 << FRAC_W);

  // The clearing pass keeps commands out right after reset.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A read passes through the normalizer, so results never come back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on consecutive cycles");

  // A zero sum gives zero components.
  a_zero_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_zero_sum) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("nonzero normal with zero sum");

  // Unit components stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_normal_x <= ONE_Q && out_normal_x >= MONE_Q &&
                    out_normal_y <= ONE_Q && out_normal_y >= MONE_Q &&
                    out_normal_z <= ONE_Q && out_normal_z >= MONE_Q))
    else $error("normal component out of range");

endmodule

bind vertex_normal_accumulator_core vna_port_checks u_vna_checker (.*);

/* test/vna_checker.sv */
// Checker for the vertex normal accumulator: predicts every read and compares the results.
module vna_checker import vna_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [VIDX_W-1:0]            in_index_a,
  input  logic [VIDX_W-1:0]            in_index_b,
  input  logic [VIDX_W-1:0]            in_index_c,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic                         out_strobe,
  input  logic signed [NORM_W-1:0]     out_normal_x,
  input  logic signed [NORM_W-1:0]     out_normal_y,
  input  logic signed [NORM_W-1:0]     out_normal_z,
  input  logic                         out_zero_sum,
  input  logic                         out_saturated,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
    logic                     zero;
    logic                     sat;
  } normal_t;

  localparam longint SUM_HI = (64'sd1 <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  // Private copy of the block's state.
  longint  vert_pos[MAX_VERTICES][3];
  longint  normal_sum[MAX_VERTICES][3];
  bit      sum_clamped[MAX_VERTICES];
  normal_t expected_normals[$];

  initial fail_count = 0;
  initial pending = 0;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Adds b to a with clamping to the signed sum range.
  function automatic longint clamp_add(input longint a, input longint b, ref bit hit);
    if (b > 0 && a > SUM_HI - b) begin
      hit = 1;
      return SUM_HI;
    end
    if (b < 0 && a < SUM_LO - b) begin
      hit = 1;
      return SUM_LO;
    end
    return a + b;
  endfunction

  // Scales the sum of one vertex to unit length in Q1.14.
  function automatic normal_t unit_normal(input int v);
    longint unsigned mag[3];
    longint unsigned big, sq, root, q;
    int bl;
    normal_t r;
    r = '0;
    r.sat = sum_clamped[v];
    big = 0;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = normal_sum[v][k] < 0 ? -normal_sum[v][k] : normal_sum[v][k];
      if (mag[k] > big) big = mag[k];
    end
    if (big == 0) begin
      r.zero = 1;
      return r;
    end
    bl = 0;
    while (bl < 64 && (big >> bl) != 0) bl++;
    for (int k = 0; k < 3; k++) begin
      if (bl > MAG_W) mag[k] >>= (bl - MAG_W);
      else mag[k] <<= (MAG_W - bl);
      sq += mag[k] * mag[k];
    end
    root = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 16384 + root / 2) / root;
      if (normal_sum[v][k] < 0) q = -q;
      case (k)
        0: r.x = q[NORM_W-1:0];
        1: r.y = q[NORM_W-1:0];
        default: r.z = q[NORM_W-1:0];
      endcase
    end
    return r;
  endfunction

  // Applies one accepted command to the private state.
  task automatic apply_command();
    longint e1[3], e2[3], n[3];
    int idx[3];
    bit hit;
    case (in_kind)
      KIND_CLEAR: begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
          for (int k = 0; k < 3; k++) normal_sum[v][k] = 0;
          sum_clamped[v] = 0;
        end
      end
      KIND_WRITE: begin
        vert_pos[in_index_a][0] = longint'(in_pos_x);
        vert_pos[in_index_a][1] = longint'(in_pos_y);
        vert_pos[in_index_a][2] = longint'(in_pos_z);
      end
      KIND_TRI: begin
        idx[0] = int'(in_index_a);
        idx[1] = int'(in_index_b);
        idx[2] = int'(in_index_c);
        for (int k = 0; k < 3; k++) begin
          e1[k] = vert_pos[idx[1]][k] - vert_pos[idx[0]][k];
          e2[k] = vert_pos[idx[2]][k] - vert_pos[idx[1]][k];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        // Corners add in order, so a repeated corner adds twice.
        for (int c = 0; c < 3; c++) begin
          hit = 0;
          for (int k = 0; k < 3; k++)
            normal_sum[idx[c]][k] = clamp_add(normal_sum[idx[c]][k], n[k], hit);
          if (hit) sum_clamped[idx[c]] = 1;
        end
      end
      default: expected_normals.push_back(unit_normal(int'(in_index_a)));
    endcase
  endtask

  initial begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      for (int k = 0; k < 3; k++) begin
        vert_pos[v][k] = 0;
        normal_sum[v][k] = 0;
      end
      sum_clamped[v] = 0;
    end
  end

  // Results are compared before the command of the same edge is applied.
  always @(posedge clk) begin
    normal_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("result transfer with no read outstanding");
        end else begin
          want = expected_normals.pop_front();
          if (out_normal_x !== want.x)
            report_mismatch($sformatf("normal_x %0d, want %0d", out_normal_x, want.x));
          if (out_normal_y !== want.y)
            report_mismatch($sformatf("normal_y %0d, want %0d", out_normal_y, want.y));
          if (out_normal_z !== want.z)
            report_mismatch($sformatf("normal_z %0d, want %0d", out_normal_z, want.z));
          if (out_zero_sum !== want.zero)
            report_mismatch($sformatf("zero_sum %b, want %b", out_zero_sum, want.zero));
          if (out_saturated !== want.sat)
            report_mismatch($sformatf("saturated %b, want %b", out_saturated, want.sat));
        end
      end
      if (start && !busy) apply_command();
    end
    pending = expected_normals.size();
  end

endmodule

/* test/tb_vertex_normal_accumulator_core.sv */
// Testbench top: drives commands into the accumulator and gives the verdict.
module tb_vertex_normal_accumulator_core import vna_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [1:0]                   in_kind;
  logic [VIDX_W-1:0]            in_index_a;
  logic [VIDX_W-1:0]            in_index_b;
  logic [VIDX_W-1:0]            in_index_c;
  logic signed [COORD_BITS-1:0] in_pos_x;
  logic signed [COORD_BITS-1:0] in_pos_y;
  logic signed [COORD_BITS-1:0] in_pos_z;
  logic                         out_strobe;
  logic signed [NORM_W-1:0]     out_normal_x;
  logic signed [NORM_W-1:0]     out_normal_y;
  logic signed [NORM_W-1:0]     out_normal_z;
  logic                         out_zero_sum;
  logic                         out_saturated;
  int                           fail_count;
  int                           pending;

  int  written_list[$];
  bit  written[MAX_VERTICES];
  bit  no_gaps;

  vertex_normal_accumulator_core DUT (.*);

  vna_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Puts one command on the port and holds it until the transfer.
  task automatic send_cmd(input logic [1:0] kind, input int a, input int b, input int c,
                          input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    if (!no_gaps && $urandom_range(99) < 34) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1;
    in_kind    <= kind;
    in_index_a <= VIDX_W'(a);
    in_index_b <= VIDX_W'(b);
    in_index_c <= VIDX_W'(c);
    in_pos_x   <= x;
    in_pos_y   <= y;
    in_pos_z   <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == KIND_WRITE && !written[a]) begin
      written[a] = 1;
      written_list.push_back(a);
    end
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  function automatic int pick_index();
    return written_list.size() > 0 && $urandom_range(3) != 0 ?
           pick_written() : int'($urandom_range(MAX_VERTICES - 1));
  endfunction

  initial begin
    int sel;
    rst_n = 0;
    start = 0;
    in_kind = KIND_CLEAR;
    in_index_a = '0;
    in_index_b = '0;
    in_index_c = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    no_gaps = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Directed: extreme coordinates and indexes, every command kind.
    send_cmd(KIND_WRITE, 0, 1023, 1023, 16'h7fff, 16'h7fff, 16'h7fff);
    send_cmd(KIND_WRITE, 1023, 0, 0, 16'h8000, 16'h8000, 16'h8000);
    send_cmd(KIND_WRITE, 1, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
    send_cmd(KIND_WRITE, 2, 0, 0, 16'h8000, 16'h0000, 16'h7fff);
    send_cmd(KIND_WRITE, 3, 0, 0, 16'h0100, 16'h0000, 16'h0000);
    send_cmd(KIND_WRITE, 4, 0, 0, 16'h0000, 16'h0100, 16'h0000);
    send_cmd(KIND_READ, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_TRI, 0, 1, 2, 16'hffff, 16'hffff, 16'hffff);
    send_cmd(KIND_TRI, 1023, 1, 2, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_TRI, 3, 4, 0, 16'h0000, 16'h0000, 16'h0000);
    // Repeated corners: each named corner adds in turn.
    send_cmd(KIND_TRI, 3, 3, 4, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_TRI, 1, 2, 1, 16'h0000, 16'h0000, 16'h0000);
    // Collinear corners give a zero normal.
    send_cmd(KIND_TRI, 0, 1023, 0, 16'h0000, 16'h0000, 16'h0000);
    for (int v = 0; v < 5; v++)
      send_cmd(KIND_READ, v, 1023, 1023, 16'hffff, 16'hffff, 16'hffff);
    send_cmd(KIND_READ, 1023, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_READ, 512, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    // Clear keeps positions but zeroes the sums.
    send_cmd(KIND_CLEAR, 1023, 1023, 1023, 16'hffff, 16'hffff, 16'hffff);
    send_cmd(KIND_READ, 1, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_TRI, 0, 1, 2, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(KIND_READ, 2, 0, 0, 16'h0000, 16'h0000, 16'h0000);

    // Random commands: triangles on written vertices, writes and reads, and rare clears.
    for (int i = 0; i < 1600; i++) begin
      no_gaps = (i >= 600 && i < 900);
      sel = $urandom_range(99);
      if (sel < 2)
        send_cmd(KIND_CLEAR, $urandom, $urandom, $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom));
      else if (sel < 25)
        send_cmd(KIND_WRITE, pick_index(), $urandom, $urandom,
                 rand_coord(), rand_coord(), rand_coord());
      else if (sel < 68)
        send_cmd(KIND_TRI, pick_written(), pick_written(), pick_written(),
                 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_cmd(KIND_READ, pick_index(), $urandom, $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom));
    end
    start <= 0;

    // Drain outstanding reads, then let a trailing clear or triangle finish.
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
